>>> sv/csfd_pkg.sv
// shared types, constants and register map for the can signal field decoder
package csfd_pkg;

    // entry count limits and default
    localparam int MAX_ENTRIES     = 2;
    localparam int NUM_ENTRIES_DEF = 2;

    // field widths
    localparam int ID_W    = 29;
    localparam int DATA_W  = 64;
    localparam int GROUP_W = 16;
    localparam int START_W = 6;
    localparam int COUNT_W = 7;
    localparam int RES_W   = 32;
    localparam int LIM_W   = 32;
    localparam int VAL_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = DATA_W + RES_W;
    localparam int IDX_W   = 1;

    // apb port
    localparam int APB_DATA_W = 64;
    localparam int ADDR_W     = 6;
    localparam int ADDR_LSB   = 3;

    // register index within one entry
    localparam int REGS_PER_ENTRY = 3;
    localparam int REG_LAYOUT     = 0;
    localparam int REG_RES        = 1;
    localparam int REG_LIMITS     = 2;

    // layout register fields
    localparam int LAYOUT_W     = 29;
    localparam int START_LSB    = 16;
    localparam int COUNT_LSB    = 22;

    // reset values of the entry registers
    localparam logic [LAYOUT_W-1:0] LAYOUT_RST [MAX_ENTRIES] =
        '{29'd68743172, 29'd69271287};
    localparam logic [RES_W-1:0] RES_RST [MAX_ENTRIES] =
        '{32'd8192, 32'd3277};
    localparam logic [2*LIM_W-1:0] LIMITS_RST [MAX_ENTRIES] =
        '{64'd34492882354176, 64'd13795434954752};

    // input transfer payload
    typedef struct packed {
        logic [ID_W-1:0]   can_id;
        logic [DATA_W-1:0] frame_data;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] scaled_value;
        logic                    in_range;
        logic                    last_of_frame;
    } t_out_item;

    // decoded configuration of one entry
    typedef struct packed {
        logic [GROUP_W-1:0]      group_num;
        logic [START_W-1:0]      start_bit;
        logic [COUNT_W-1:0]      bit_count;
        logic [RES_W-1:0]        resolution;
        logic signed [LIM_W-1:0] min_val;
        logic signed [LIM_W-1:0] max_val;
    } t_entry_cfg;

    // load enables of the pipeline stages
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_stage_en;

    // result of one lane at the last stage
    typedef struct packed {
        logic             match;
        logic             in_range;
        logic [VAL_W-1:0] value;
    } t_lane_res;

endpackage

>>> sv/can_signal_field_decoder.sv
// top level of the can signal field decoder
// Decodes up to NUM_ENTRIES signal fields from each CAN frame. A frame passes a
// four-stage pipeline (field extraction, two 32x32 partial products, 96-bit product
// sum, range check and offset add) and then an output register. A frame enters
// every cycle as long as at most one entry matches its group number and the output
// is not stalled; a frame that matches two entries holds the last stage until both
// results are sent, since the output register sends one result per cycle when not
// stalled, entry 0 first. Frames with no match give no result. There is no clearing
// pass after reset. Registers sit at byte address 8*i on the 64-bit APB port and
// must only be written while no frame is in flight.
module can_signal_field_decoder #(
    parameter int NUM_ENTRIES = csfd_pkg::NUM_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  csfd_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output csfd_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csfd_pkg::ADDR_W-1:0]     paddr,
    input  logic [csfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    csfd_pkg::t_entry_cfg cfg [NUM_ENTRIES];
    csfd_pkg::t_lane_res  res [NUM_ENTRIES];
    csfd_pkg::t_stage_en  en;
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic                 take;

    assign pready = 1'b1;

    csfd_regs #(.NUM_ENTRIES(NUM_ENTRIES)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // stage advance: a stage loads when empty or when its content moves on
    always_comb begin
        en.en4 = !r_v4 || take;
        en.en3 = !r_v3 || en.en4;
        en.en2 = !r_v2 || en.en3;
        en.en1 = !r_v1 || en.en2;
    end

    assign o_in_stall = !en.en1;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.en1) begin
                r_v1 <= i_in_valid;
            end
            if (en.en2) begin
                r_v2 <= r_v1;
            end
            if (en.en3) begin
                r_v3 <= r_v2;
            end
            if (en.en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // one decode lane per entry
    for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_lane
        csfd_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_item (i_in_data),
            .i_cfg  (cfg[e]),
            .o_res  (res[e])
        );
    end

    csfd_serial #(.NUM_ENTRIES(NUM_ENTRIES)) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v4    (r_v4),
        .i_res   (res),
        .o_take  (take),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

>>> sv/csfd_regs.sv
// apb configuration registers of the signal entries
module csfd_regs #(
    parameter int NUM_ENTRIES = csfd_pkg::NUM_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csfd_pkg::ADDR_W-1:0]     paddr,
    input  logic [csfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csfd_pkg::APB_DATA_W-1:0] prdata,
    output csfd_pkg::t_entry_cfg            o_cfg [NUM_ENTRIES]
);

    localparam int IDXW = csfd_pkg::ADDR_W - csfd_pkg::ADDR_LSB;

    logic [csfd_pkg::LAYOUT_W-1:0]  r_layout [NUM_ENTRIES];
    logic [csfd_pkg::RES_W-1:0]     r_res    [NUM_ENTRIES];
    logic [2*csfd_pkg::LIM_W-1:0]   r_limits [NUM_ENTRIES];
    logic [IDXW-1:0]                reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[csfd_pkg::ADDR_W-1:csfd_pkg::ADDR_LSB];
    assign wr_en   = psel & penable & pwrite;

    // register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                r_layout[e] <= csfd_pkg::LAYOUT_RST[e];
                r_res[e]    <= csfd_pkg::RES_RST[e];
                r_limits[e] <= csfd_pkg::LIMITS_RST[e];
            end
        end else if (wr_en) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                if (reg_idx == IDXW'(e * csfd_pkg::REGS_PER_ENTRY + csfd_pkg::REG_LAYOUT)) begin
                    r_layout[e] <= pwdata[csfd_pkg::LAYOUT_W-1:0];
                end
                if (reg_idx == IDXW'(e * csfd_pkg::REGS_PER_ENTRY + csfd_pkg::REG_RES)) begin
                    r_res[e] <= pwdata[csfd_pkg::RES_W-1:0];
                end
                if (reg_idx == IDXW'(e * csfd_pkg::REGS_PER_ENTRY + csfd_pkg::REG_LIMITS)) begin
                    r_limits[e] <= pwdata;
                end
            end
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (reg_idx == IDXW'(e * csfd_pkg::REGS_PER_ENTRY + csfd_pkg::REG_LAYOUT)) begin
                prdata = csfd_pkg::APB_DATA_W'(r_layout[e]);
            end
            if (reg_idx == IDXW'(e * csfd_pkg::REGS_PER_ENTRY + csfd_pkg::REG_RES)) begin
                prdata = csfd_pkg::APB_DATA_W'(r_res[e]);
            end
            if (reg_idx == IDXW'(e * csfd_pkg::REGS_PER_ENTRY + csfd_pkg::REG_LIMITS)) begin
                prdata = r_limits[e];
            end
        end
    end

    // unpack entry fields
    always_comb begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            o_cfg[e].group_num  = r_layout[e][csfd_pkg::GROUP_W-1:0];
            o_cfg[e].start_bit  =
                r_layout[e][csfd_pkg::START_LSB +: csfd_pkg::START_W];
            o_cfg[e].bit_count  =
                r_layout[e][csfd_pkg::COUNT_LSB +: csfd_pkg::COUNT_W];
            o_cfg[e].resolution = r_res[e];
            o_cfg[e].min_val    = r_limits[e][csfd_pkg::LIM_W-1:0];
            o_cfg[e].max_val    = r_limits[e][2*csfd_pkg::LIM_W-1:csfd_pkg::LIM_W];
        end
    end

endmodule

>>> sv/csfd_lane.sv
// four-stage decode pipeline of one signal entry: extract, multiply, sum, check
module csfd_lane (
    input  logic                 i_clk,
    input  csfd_pkg::t_stage_en  i_en,
    input  csfd_pkg::t_in_item   i_item,
    input  csfd_pkg::t_entry_cfg i_cfg,
    output csfd_pkg::t_lane_res  o_res
);

    localparam int HALF_W = csfd_pkg::DATA_W / 2;

    logic                             r_match1, r_match2, r_match3, r_match4;
    logic [csfd_pkg::DATA_W-1:0]      r_field1;
    logic [2*HALF_W-1:0]              r_plo2, r_phi2;
    logic [csfd_pkg::PROD_W-1:0]      r_prod3;
    logic [csfd_pkg::LIM_W-1:0]       r_diff3;
    logic                             r_lim_ok3;
    logic                             r_ok4;
    logic [csfd_pkg::VAL_W-1:0]       r_val4;

    logic                             n_match1;
    logic [csfd_pkg::DATA_W-1:0]      n_field1, shifted, mask;
    logic [csfd_pkg::LIM_W:0]         diff_ext;
    logic                             n_ok4;
    logic [csfd_pkg::VAL_W-1:0]       base_val;

    // group match and bit field extraction
    always_comb begin
        n_match1 = (i_item.can_id[8 +: csfd_pkg::GROUP_W] == i_cfg.group_num);
        shifted  = i_item.frame_data >> i_cfg.start_bit;
        if (i_cfg.bit_count >= csfd_pkg::COUNT_W'(csfd_pkg::DATA_W)) begin
            mask = '1;
        end else begin
            mask = ~({csfd_pkg::DATA_W{1'b1}} << i_cfg.bit_count[csfd_pkg::START_W-1:0]);
        end
        n_field1 = shifted & mask;
    end

    // limit span, range check and offset base
    assign diff_ext = {i_cfg.max_val[csfd_pkg::LIM_W-1], i_cfg.max_val}
                    - {i_cfg.min_val[csfd_pkg::LIM_W-1], i_cfg.min_val};
    assign n_ok4 = r_lim_ok3
                && (r_prod3[csfd_pkg::PROD_W-1:csfd_pkg::VAL_W] == '0)
                && (r_prod3[csfd_pkg::VAL_W-1:0] <= {r_diff3, csfd_pkg::FRAC_W'(0)});
    assign base_val = {i_cfg.min_val, csfd_pkg::FRAC_W'(0)};

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_match1 <= n_match1;
            r_field1 <= n_field1;
        end
        if (i_en.en2) begin
            r_match2 <= r_match1;
            r_plo2   <= (2*HALF_W)'(r_field1[HALF_W-1:0]) * (2*HALF_W)'(i_cfg.resolution);
            r_phi2   <= (2*HALF_W)'(r_field1[2*HALF_W-1:HALF_W])
                      * (2*HALF_W)'(i_cfg.resolution);
        end
        if (i_en.en3) begin
            r_match3  <= r_match2;
            r_prod3   <= csfd_pkg::PROD_W'(r_plo2)
                       + {r_phi2, HALF_W'(0)};
            r_diff3   <= diff_ext[csfd_pkg::LIM_W-1:0];
            r_lim_ok3 <= !diff_ext[csfd_pkg::LIM_W];
        end
        if (i_en.en4) begin
            r_match4 <= r_match3;
            r_ok4    <= n_ok4;
            r_val4   <= n_ok4 ? (base_val + r_prod3[csfd_pkg::VAL_W-1:0]) : '0;
        end
    end

    assign o_res.match    = r_match4;
    assign o_res.in_range = r_ok4;
    assign o_res.value    = r_val4;

endmodule

>>> sv/csfd_serial.sv
// output register that sends the matching lanes of one frame in entry order
module csfd_serial #(
    parameter int NUM_ENTRIES = csfd_pkg::NUM_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_v4,
    input  csfd_pkg::t_lane_res i_res [NUM_ENTRIES],
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_stall,
    output csfd_pkg::t_out_item o_data
);

    logic [NUM_ENTRIES-1:0]          r_sent;
    logic                            r_out_valid;
    csfd_pkg::t_out_item             r_out;
    logic [NUM_ENTRIES-1:0]          pend;
    logic [csfd_pkg::IDX_W-1:0]      sel;
    logic                            others;
    logic                            out_free;
    logic                            emit;
    csfd_pkg::t_out_item             n_out;

    // lanes still to send and the lowest one among them
    always_comb begin
        sel    = '0;
        others = 1'b0;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            pend[e] = i_res[e].match & ~r_sent[e];
        end
        for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
            if (pend[e]) begin
                sel = csfd_pkg::IDX_W'(e);
            end
        end
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (pend[e] && (csfd_pkg::IDX_W'(e) != sel)) begin
                others = 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = i_v4 && (pend != '0) && out_free;
    assign o_take   = i_v4 && ((pend == '0) || (out_free && !others));

    // next result
    always_comb begin
        n_out.entry_index   = sel;
        n_out.scaled_value  = i_res[sel].value;
        n_out.in_range      = i_res[sel].in_range;
        n_out.last_of_frame = !others;
    end

    // sent flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_sent <= '0;
            end else if (emit) begin
                r_sent[sel] <= 1'b1;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> sv/csfd_checker.sv
// port-level checks of the can signal field decoder and their bind
module csfd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input csfd_pkg::t_in_item              i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input csfd_pkg::t_out_item             o_out_data,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [csfd_pkg::ADDR_W-1:0]     paddr,
    input logic [csfd_pkg::APB_DATA_W-1:0] pwdata,
    input logic [csfd_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

    // no result leaves the block right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an out of range result carries a zero value
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.in_range |-> o_out_data.scaled_value == '0)
        else $error("out of range value not zero");

    // a result that is not last of its frame is entry 0
    a_first_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_frame |-> o_out_data.entry_index == '0)
        else $error("non-final result not from entry 0");

    // the second result of a frame follows right after the first when the output is not stalled
    a_second_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_frame && !i_out_stall
        |=> o_out_valid && o_out_data.last_of_frame && (o_out_data.entry_index != '0))
        else $error("second result of frame missing");

endmodule

bind can_signal_field_decoder csfd_checker u_csfd_checker (.*);
